@@ rtl/lis_pkg.sv @@
// lis_pkg: shared types and constants for the longest increasing subsequence block
// used by longest_increasing_subsequence and lis_checker; no dependencies
package lis_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

endpackage

@@ rtl/longest_increasing_subsequence.sv @@
// longest_increasing_subsequence: quadratic dp over a stored sequence, one
// table memory holding value, best length and predecessor for each entry
// depends on lis_pkg
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+--------------------------------
//  in      | sink      | in_valid / in_stall | value, last_item
//  out     | source    | out_valid/out_stall | word, is_length, last_result
//
// an item is accepted, scanned against every stored entry through the table
// memory (one read per cycle, each read word registered before it is compared,
// then a drain of the last read) and written back as a new entry.
// the final item then emits the length and then the L values, L being the
// subsequence length, each output item held while out_stall is set.
// once MAX_ITEMS entries are held, a further item is not stored; a final
// one still starts the output.
// rst_n clears the entry count and control; the table itself is not cleared.
module longest_increasing_subsequence #(
    parameter int MAX_ITEMS = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  lis_pkg::word_t value,
    input  logic          last_item,
    output logic          out_valid,
    input  logic          out_stall,
    output lis_pkg::word_t word,
    output logic          is_length,
    output logic          last_result
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int ENT_W = lis_pkg::WORD_W + CNT_W + IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [CNT_W-1:0] cur_len_reg, cur_len_next;
    logic [IDX_W-1:0] cur_pred_reg, cur_pred_next;
    logic [CNT_W-1:0] best_len_reg, best_len_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] k_reg, k_next;
    lis_pkg::word_t   v_reg, v_next;
    logic             last_reg, last_next;

    logic             out_valid_reg, out_valid_next;
    lis_pkg::word_t   word_reg, word_next;
    logic             is_length_reg, is_length_next;
    logic             last_result_reg, last_result_next;

    logic [ENT_W-1:0] mem [MAX_ITEMS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [ENT_W-1:0] mem_wd;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ra;

    lis_pkg::word_t   rd_value;
    logic [CNT_W-1:0] rd_len;
    logic [IDX_W-1:0] rd_pred;
    logic             accept;
    logic             out_free;
    logic             issue;
    logic             chain_end;

    assign rd_value = rd_data_reg[ENT_W-1 -: lis_pkg::WORD_W];
    assign rd_len   = rd_data_reg[IDX_W +: CNT_W];
    assign rd_pred  = rd_data_reg[IDX_W-1:0];

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || !out_stall;
    assign issue       = (state_reg == S_SCAN) && (ptr_reg < count_reg);
    assign chain_end   = (rd_pred == idx_reg) || (k_reg >= MAX_CNT);

    assign out_valid   = out_valid_reg;
    assign word        = word_reg;
    assign is_length   = is_length_reg;
    assign last_result = last_result_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        pend_next        = 1'b0;
        pidx_next        = pidx_reg;
        cur_len_next     = cur_len_reg;
        cur_pred_next    = cur_pred_reg;
        best_len_next    = best_len_reg;
        best_idx_next    = best_idx_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        v_next           = v_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && out_stall;
        word_next        = word_reg;
        is_length_next   = is_length_reg;
        last_result_next = last_result_reg;
        mem_we           = 1'b0;
        mem_wa           = count_reg[IDX_W-1:0];
        mem_wd           = {v_reg, cur_len_reg, cur_pred_reg};
        mem_re           = 1'b0;
        mem_ra           = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    v_next    = value;
                    last_next = last_item;
                    if (count_reg < MAX_CNT)
                    begin
                        ptr_next      = '0;
                        cur_len_next  = CNT_W'(1);
                        cur_pred_next = count_reg[IDX_W-1:0];
                        state_next    = S_SCAN;
                    end
                    else if (last_item)
                    begin
                        state_next = S_LEN;
                    end
                end
            end
            S_SCAN:
            begin
                // read entry ptr while comparing the entry read last cycle
                if (issue)
                begin
                    mem_re   = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                pend_next = issue;
                pidx_next = ptr_reg[IDX_W-1:0];
                if (pend_reg && (v_reg > rd_value) && (rd_len >= cur_len_reg))
                begin
                    cur_len_next  = rd_len + CNT_W'(1);
                    cur_pred_next = pidx_reg;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                if (cur_len_reg > best_len_reg)
                begin
                    best_len_next = cur_len_reg;
                    best_idx_next = count_reg[IDX_W-1:0];
                end
                state_next = last_reg ? S_LEN : S_IDLE;
            end
            S_LEN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    word_next        = {{(lis_pkg::WORD_W-CNT_W){1'b0}}, best_len_reg};
                    is_length_next   = 1'b1;
                    last_result_next = 1'b0;
                    mem_re           = 1'b1;
                    mem_ra           = best_idx_reg;
                    idx_next         = best_idx_reg;
                    k_next           = CNT_W'(1);
                    state_next       = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    word_next        = rd_value;
                    is_length_next   = 1'b0;
                    last_result_next = chain_end;
                    if (chain_end)
                    begin
                        count_next    = '0;
                        best_len_next = '0;
                        best_idx_next = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        mem_re   = 1'b1;
                        mem_ra   = rd_pred;
                        idx_next = rd_pred;
                        k_next   = k_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            best_len_reg  <= '0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            best_len_reg  <= best_len_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        pidx_reg        <= pidx_next;
        cur_len_reg     <= cur_len_next;
        cur_pred_reg    <= cur_pred_next;
        idx_reg         <= idx_next;
        k_reg           <= k_next;
        v_reg           <= v_next;
        last_reg        <= last_next;
        word_reg        <= word_next;
        is_length_reg   <= is_length_next;
        last_result_reg <= last_result_next;
    end

endmodule

@@ rtl/lis_checker.sv @@
// lis_checker: port-level assertions for longest_increasing_subsequence
// depends on lis_pkg; bound to the top level at the end of this file
module lis_checker #(
    parameter int MAX_ITEMS = 63
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input lis_pkg::word_t value,
    input logic           last_item,
    input logic           out_valid,
    input logic           out_stall,
    input lis_pkg::word_t word,
    input logic           is_length,
    input logic           last_result
);

    localparam lis_pkg::word_t MAX_WORD = lis_pkg::WORD_W'(MAX_ITEMS);

    // a stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word) &&
                                   $stable(is_length) && $stable(last_result))
    else $error("stalled out item changed");

    // a stalled in item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(value) && $stable(last_item))
    else $error("stalled in item changed");

    // the length item is never the last of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_length |-> !last_result)
    else $error("length item marked last");

    // the length lies between one and the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_length |-> (word >= lis_pkg::word_t'(1)) && (word <= MAX_WORD))
    else $error("length out of range");

    // a final item always starts the result phase
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_item |=> in_stall)
    else $error("final item did not start results");

endmodule

bind longest_increasing_subsequence lis_checker #(
    .MAX_ITEMS(MAX_ITEMS)
) u_lis_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .last_item(last_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word(word),
    .is_length(is_length),
    .last_result(last_result)
);
